// ===== rtl/core/tla_pkg.sv =====
// Shared types, constants and helpers of the thermal level alarm monitor.
package tla_pkg;

	localparam int SENSORS_PER_CLASS_DEF = 8;
	localparam int CLASS_W = 2;
	localparam int INDEX_W = 3;
	localparam int TEMP_W = 16;
	localparam int MASK_W = 4;
	localparam int CNT_W = 6;
	localparam int LEVELS = 4;
	localparam int IN_TDATA_W = 80;
	localparam int OUT_TDATA_W = 16;

	localparam logic [CNT_W-1:0] INTERVAL_RESET = 6'd30;
	localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

	typedef enum logic [1:0] {
		LVL_NORMAL = 2'd0,
		LVL_WARN   = 2'd1,
		LVL_HIGH   = 2'd2,
		LVL_CRIT   = 2'd3
	} level_t;

	typedef struct packed {
		logic [LEVELS-1:0][CNT_W-1:0] count;
		logic                         alarm;
		level_t                       level;
	} entry_t;

	typedef struct packed {
		logic [MASK_W-1:0]        mask;
		logic signed [TEMP_W-1:0] crit;
		logic signed [TEMP_W-1:0] high;
		logic signed [TEMP_W-1:0] warn;
		logic signed [TEMP_W-1:0] reading;
	} item_t;

	// Packed so that the level sits in the lowest bits, matching the output word.
	typedef struct packed {
		logic   fan_release;
		logic   fan_claim;
		logic   alarm_ended;
		logic   alarm_started;
		logic   log_event;
		logic   report_valid;
		logic   alarm_active;
		level_t level;
	} result_t;

	function automatic entry_t entry_reset();
		entry_t e;
		e.level = LVL_NORMAL;
		e.alarm = 1'b0;
		for (int k = 0; k < LEVELS; k++) begin
			e.count[k] = INTERVAL_RESET;
		end
		return e;
	endfunction

endpackage

// ===== rtl/core/tla_entry_ram.sv =====
// Per-sensor state memory with valid bits and write-to-read forwarding.
module tla_entry_ram
	import tla_pkg::*;
#(
	parameter int DEPTH = 4 * SENSORS_PER_CLASS_DEF,
	parameter int AW = $clog2(4 * SENSORS_PER_CLASS_DEF)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	output entry_t        rd_data
);

	entry_t             mem [DEPTH];
	entry_t             rd_q;
	logic [AW-1:0]      rd_addr_q;
	logic               rd_vld_q;
	logic [DEPTH-1:0]   vld_q;
	entry_t             fwd_q;
	logic [AW-1:0]      fwd_addr_q;
	logic               fwd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
			rd_addr_q <= '0;
			fwd_vld_q <= 1'b0;
			fwd_addr_q <= '0;
			fwd_q <= entry_reset();
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
				fwd_vld_q <= 1'b1;
				fwd_addr_q <= wr_addr;
				fwd_q <= wr_data;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
				rd_addr_q <= rd_addr;
			end
		end
	end

	// The latest write always wins, since the memory read may have missed it.
	always_comb begin
		if (fwd_vld_q && fwd_addr_q == rd_addr_q) begin
			rd_data = fwd_q;
		end else if (rd_vld_q) begin
			rd_data = rd_q;
		end else begin
			rd_data = entry_reset();
		end
	end

endmodule

// ===== rtl/core/tla_update.sv =====
// Level decision, log counting, alarm and fan ownership update for one reading.
module tla_update
	import tla_pkg::*;
(
	input  entry_t           cur,
	input  item_t            item,
	input  logic             idx_ok,
	input  logic [CNT_W-1:0] interval,
	input  logic [CNT_W-1:0] fan_cnt,
	output entry_t           nxt,
	output logic             wr,
	output result_t          res,
	output logic [CNT_W-1:0] fan_nxt
);

	localparam logic signed [TEMP_W-1:0] TempZero = '0;

	level_t           lv;
	logic             cnt_en;
	logic [CNT_W-1:0] c;

	always_comb begin
		nxt = cur;
		res = '0;
		fan_nxt = fan_cnt;
		wr = idx_ok;
		lv = LVL_NORMAL;
		cnt_en = 1'b0;
		c = '0;
		if (idx_ok) begin
			res.report_valid = 1'b1;
			if (item.reading <= TempZero) begin
				nxt.level = LVL_NORMAL;
			end else if (item.reading < item.warn) begin
				lv = LVL_NORMAL;
				cnt_en = 1'b1;
				nxt.level = LVL_NORMAL;
				if (cur.alarm) begin
					res.alarm_ended = 1'b1;
					fan_nxt = (fan_cnt == '0) ? '0 : fan_cnt - 1'b1;
					res.fan_release = (fan_nxt == '0);
				end
				nxt.alarm = 1'b0;
			end else if (item.reading < item.high) begin
				lv = LVL_WARN;
				cnt_en = 1'b1;
				nxt.level = LVL_WARN;
			end else if (item.reading < item.crit) begin
				lv = LVL_HIGH;
				cnt_en = 1'b1;
				nxt.level = LVL_HIGH;
			end else begin
				lv = LVL_CRIT;
				cnt_en = 1'b1;
				if (cur.alarm) begin
					res.report_valid = 1'b0;
				end else begin
					nxt.alarm = 1'b1;
					nxt.level = LVL_CRIT;
					res.alarm_started = 1'b1;
					fan_nxt = (fan_cnt == COUNT_MAX) ? COUNT_MAX : fan_cnt + 1'b1;
					res.fan_claim = (fan_nxt == CNT_W'(1));
				end
			end
			if (cnt_en && item.mask[lv]) begin
				c = cur.count[lv];
				if (c != COUNT_MAX) begin
					c = c + 1'b1;
				end
				nxt.count[lv] = c;
				if (c > interval) begin
					for (int k = 0; k < LEVELS; k++) begin
						nxt.count[k] = interval;
					end
					nxt.count[lv] = '0;
					res.log_event = 1'b1;
				end
			end
			res.level = nxt.level;
			res.alarm_active = nxt.alarm;
		end
	end

endmodule

// ===== rtl/core/thermal_level_alarm_monitor.sv =====
// Top level of the thermal level alarm monitor: input stage, state memory and output register.
// Path: an accepted word is registered in the input stage while its sensor entry is read; the
// update then writes the entry back and registers the result word in the output register.
// Throughput: one word per cycle while m_tready does not hold the output, also for back-to-back
// readings of the same sensor, set by one read-modify-write of the sensor entry per cycle with
// write forwarding. Reset clears all sensor entries at once through per-entry valid bits; the
// block is ready for words as soon as reset is released, and the repeat interval resets to 30.
module thermal_level_alarm_monitor
	import tla_pkg::*;
#(
	parameter int SENSORS_PER_CLASS = SENSORS_PER_CLASS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CNT_W-1:0]       cfg_wr_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// Fields from bit 0: sensor_class, sensor_index, reading, warn_limit, high_limit,
	// critical_limit, log_enable_mask, zero fill.
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// Fields from bit 0: level, alarm_active, report_valid, log_event, alarm_started,
	// alarm_ended, fan_claim, fan_release, zero fill.
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int Depth = 4 * SENSORS_PER_CLASS;
	localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

	logic [CLASS_W-1:0] cls;
	logic [INDEX_W-1:0] idx;
	item_t              item;
	logic               idx_ok;
	logic [Aw-1:0]      addr;
	logic               accept;
	logic               s1_adv;

	logic               s1_valid_q;
	item_t              item_s1;
	logic [Aw-1:0]      addr_s1;
	logic               idx_ok_s1;

	entry_t             cur;
	entry_t             nxt;
	logic               wr;
	result_t            res;
	logic [CNT_W-1:0]   fan_nxt;

	logic [CNT_W-1:0]   interval_q;
	logic [CNT_W-1:0]   fan_q;
	logic               out_valid_q;
	result_t            res_q;

	assign cls = s_tdata[1:0];
	assign idx = s_tdata[4:2];
	assign item.reading = s_tdata[20:5];
	assign item.warn = s_tdata[36:21];
	assign item.high = s_tdata[52:37];
	assign item.crit = s_tdata[68:53];
	assign item.mask = s_tdata[72:69];

	assign idx_ok = (int'(idx) < SENSORS_PER_CLASS);
	assign addr = Aw'(int'(cls) * SENSORS_PER_CLASS + int'(idx));

	assign s1_adv = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			addr_s1 <= addr;
			idx_ok_s1 <= idx_ok;
		end
	end

	tla_entry_ram #(
		.DEPTH(Depth),
		.AW(Aw)
	) u_ram (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_addr(addr),
		.wr_en(s1_adv && wr),
		.wr_addr(addr_s1),
		.wr_data(nxt),
		.rd_data(cur)
	);

	tla_update u_update (
		.cur(cur),
		.item(item_s1),
		.idx_ok(idx_ok_s1),
		.interval(interval_q),
		.fan_cnt(fan_q),
		.nxt(nxt),
		.wr(wr),
		.res(res),
		.fan_nxt(fan_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
			fan_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				interval_q <= cfg_wr_data;
			end
			if (s1_adv) begin
				fan_q <= fan_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, res_q};

	a_start_is_crit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.alarm_started |-> res_q.level == LVL_CRIT && res_q.alarm_active)
		else $error("alarm start without critical level and alarm");

	a_end_is_normal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.alarm_ended |-> res_q.level == LVL_NORMAL && !res_q.alarm_active)
		else $error("alarm end without normal level");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(addr_s1))
		else $error("stalled stage lost its word");

	a_claim_count: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && res.fan_claim |=> fan_q == CNT_W'(1))
		else $error("fan claim without an ownership count of one");

	a_no_report_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.report_valid |-> !res_q.alarm_started && !res_q.alarm_ended
			&& !res_q.fan_claim && !res_q.fan_release)
		else $error("event flagged on a word without report");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the thermal level alarm monitor: directed table, random words, stalls.
module tb_top;
	import tla_pkg::*;

	localparam int SENSORS = 4 * SENSORS_PER_CLASS_DEF;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [MASK_W-1:0]        mask;
		logic signed [TEMP_W-1:0] crit;
		logic signed [TEMP_W-1:0] high;
		logic signed [TEMP_W-1:0] warn;
		logic signed [TEMP_W-1:0] rd;
		logic [INDEX_W-1:0]       idx;
		logic [CLASS_W-1:0]       cls;
	} reading_t;

	typedef struct {
		reading_t w;
		bit       fixed;
		result_t  want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CNT_W-1:0] cfg_wr_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// Fields from bit 0: sensor_class, sensor_index, reading, warn_limit, high_limit,
	// critical_limit, log_enable_mask, zero fill.
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// Fields from bit 0: level, alarm_active, report_valid, log_event, alarm_started,
	// alarm_ended, fan_claim, fan_release, zero fill.
	logic [OUT_TDATA_W-1:0] m_tdata;

	level_t tracked_level [SENSORS];
	logic tracked_alarm [SENSORS];
	logic [CNT_W-1:0] tracked_count [SENSORS][LEVELS];
	logic [CNT_W-1:0] fan_owners;
	logic [CNT_W-1:0] repeat_interval;

	result_t pending_results [$];
	row_t directed_rows [$];
	int words_accepted = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	bit steady_phase = 1'b0;
	bit held_off = 1'b0;

	thermal_level_alarm_monitor #(
		.SENSORS_PER_CLASS(SENSORS_PER_CLASS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (steady_phase || r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic result_t outcome(level_t lv, bit al, bit rv, bit lg, bit st, bit en,
			bit cl, bit rl);
		return result_t'({rl, cl, en, st, lg, rv, al, lv});
	endfunction

	function automatic string describe(input logic [OUT_TDATA_W-1:0] v);
		result_t r;
		r = result_t'(v[$bits(result_t)-1:0]);
		return $sformatf("level %0d alarm %0b report %0b log %0b start %0b end %0b claim %0b release %0b fill %0h",
			r.level, r.alarm_active, r.report_valid, r.log_event, r.alarm_started,
			r.alarm_ended, r.fan_claim, r.fan_release, v[OUT_TDATA_W-1:$bits(result_t)]);
	endfunction

	// Sorts one reading, updates the tracked sensor entry and returns the result word.
	function automatic result_t track_reading(input reading_t w);
		result_t r;
		int e;
		level_t lv;
		logic [CNT_W-1:0] c;
		r = '0;
		r.report_valid = 1'b1;
		e = int'(w.cls) * SENSORS_PER_CLASS_DEF + int'(w.idx);
		if (w.rd <= 0) begin
			tracked_level[e] = LVL_NORMAL;
		end else begin
			if (w.rd < w.warn) begin
				lv = LVL_NORMAL;
			end else if (w.rd < w.high) begin
				lv = LVL_WARN;
			end else if (w.rd < w.crit) begin
				lv = LVL_HIGH;
			end else begin
				lv = LVL_CRIT;
			end
			if (w.mask[lv]) begin
				c = tracked_count[e][lv];
				if (c < COUNT_MAX) begin
					c = c + 1'b1;
				end
				tracked_count[e][lv] = c;
				if (c > repeat_interval) begin
					for (int k = 0; k < LEVELS; k++) begin
						tracked_count[e][k] = repeat_interval;
					end
					tracked_count[e][lv] = '0;
					r.log_event = 1'b1;
				end
			end
			case (lv)
				LVL_NORMAL: begin
					tracked_level[e] = LVL_NORMAL;
					if (tracked_alarm[e]) begin
						r.alarm_ended = 1'b1;
						if (fan_owners > 0) begin
							fan_owners = fan_owners - 1'b1;
						end
						r.fan_release = (fan_owners == 0);
					end
					tracked_alarm[e] = 1'b0;
				end
				LVL_CRIT: begin
					if (tracked_alarm[e]) begin
						r.report_valid = 1'b0;
					end else begin
						tracked_alarm[e] = 1'b1;
						tracked_level[e] = LVL_CRIT;
						r.alarm_started = 1'b1;
						if (fan_owners < COUNT_MAX) begin
							fan_owners = fan_owners + 1'b1;
						end
						r.fan_claim = (fan_owners == 1);
					end
				end
				default: begin
					tracked_level[e] = lv;
				end
			endcase
		end
		r.level = tracked_level[e];
		r.alarm_active = tracked_alarm[e];
		return r;
	endfunction

	task automatic add_row(input int c, input int i, input int rd, input int wn, input int hi,
			input int cr, input int m, input bit fixed, input result_t want);
		row_t row;
		row.w.cls = CLASS_W'(c);
		row.w.idx = INDEX_W'(i);
		row.w.rd = TEMP_W'(rd);
		row.w.warn = TEMP_W'(wn);
		row.w.high = TEMP_W'(hi);
		row.w.crit = TEMP_W'(cr);
		row.w.mask = MASK_W'(m);
		row.fixed = fixed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	task automatic offer(input reading_t w, input bit fixed, input result_t want);
		int gap;
		result_t r;
		gap = idle_cycles();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, w.mask, w.crit, w.high, w.warn, w.rd, w.idx, w.cls};
		do @(posedge clk); while (!s_tready);
		r = track_reading(w);
		pending_results.push_back(fixed ? want : r);
		words_accepted++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		logic [OUT_TDATA_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				if (mismatch_count < 10) begin
					$display("unexpected result word: %s", describe(m_tdata));
				end
				mismatch_count++;
			end else begin
				want = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, pending_results.pop_front()};
				if (m_tdata !== want) begin
					if (mismatch_count < 10) begin
						$display("result mismatch\n  expected %s\n  actual   %s",
							describe(want), describe(m_tdata));
					end
					mismatch_count++;
				end
			end
		end
	end

	// The output side stalls at random; once it holds off long enough for the block to fill up.
	initial begin : result_sink
		int run;
		int gap;
		wait (arst_n);
		forever begin
			if (!held_off && words_accepted >= 700) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			run = $urandom_range(1, 24);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = idle_cycles();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int intervals [6];
		int hot [3];
		int last_band [SENSORS];
		int e;
		int band;
		int wn;
		int hi;
		int cr;
		int rd;
		reading_t w;
		logic [CNT_W-1:0] v;

		for (int s = 0; s < SENSORS; s++) begin
			tracked_level[s] = LVL_NORMAL;
			tracked_alarm[s] = 1'b0;
			last_band[s] = 0;
			for (int k = 0; k < LEVELS; k++) begin
				tracked_count[s][k] = INTERVAL_RESET;
			end
		end
		fan_owners = '0;
		repeat_interval = INTERVAL_RESET;

		add_row(0, 0, 0, 10, 20, 30, 15, 1, outcome(LVL_NORMAL, 0, 1, 0, 0, 0, 0, 0));
		add_row(3, 7, -32768, 10, 20, 30, 15, 1, outcome(LVL_NORMAL, 0, 1, 0, 0, 0, 0, 0));
		add_row(0, 0, 5, 10, 20, 30, 1, 1, outcome(LVL_NORMAL, 0, 1, 1, 0, 0, 0, 0));
		add_row(0, 0, 5, 10, 20, 30, 1, 1, outcome(LVL_NORMAL, 0, 1, 0, 0, 0, 0, 0));
		add_row(0, 0, 15, 10, 20, 30, 2, 1, outcome(LVL_WARN, 0, 1, 1, 0, 0, 0, 0));
		add_row(0, 0, 25, 10, 20, 30, 0, 1, outcome(LVL_HIGH, 0, 1, 0, 0, 0, 0, 0));
		add_row(0, 0, 30, 10, 20, 30, 0, 1, outcome(LVL_CRIT, 1, 1, 0, 1, 0, 1, 0));
		add_row(0, 0, 32767, 10, 20, 30, 0, 1, outcome(LVL_CRIT, 1, 0, 0, 0, 0, 0, 0));
		add_row(1, 3, 100, 10, 20, 30, 8, 1, outcome(LVL_CRIT, 1, 1, 1, 1, 0, 0, 0));
		add_row(0, 0, 15, 10, 20, 30, 0, 1, outcome(LVL_WARN, 1, 1, 0, 0, 0, 0, 0));
		add_row(0, 0, 1, 10, 20, 30, 0, 1, outcome(LVL_NORMAL, 0, 1, 0, 0, 1, 0, 0));
		add_row(1, 3, 5, 10, 20, 30, 0, 1, outcome(LVL_NORMAL, 0, 1, 0, 0, 1, 0, 1));
		add_row(1, 3, 5, 10, 20, 30, 15, 0, '0);
		add_row(2, 5, 32767, -32768, -32768, -32768, 15, 1,
			outcome(LVL_CRIT, 1, 1, 1, 1, 0, 1, 0));
		add_row(2, 5, 0, 10, 20, 30, 15, 1, outcome(LVL_NORMAL, 1, 1, 0, 0, 0, 0, 0));
		add_row(2, 5, 3, 10, 20, 30, 15, 0, '0);
		add_row(2, 4, 100, 32767, -5, 0, 15, 0, '0);
		add_row(2, 4, 32766, -1, 32767, -100, 5, 0, '0);
		add_row(2, 4, 32767, 1, 2, 32767, 10, 0, '0);
		add_row(2, 4, 1, 1, 1, 2, 15, 0, '0);
		add_row(3, 7, 32767, 32767, 32767, 32767, 15, 0, '0);
		add_row(3, 7, 1, 32767, 32767, 32767, 0, 0, '0);
		add_row(1, 6, -1, -100, -50, -10, 15, 1, outcome(LVL_NORMAL, 0, 1, 0, 0, 0, 0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			offer(directed_rows[n].w, directed_rows[n].fixed, directed_rows[n].want);
		end

		intervals = '{30, 63, 1, 62, 0, 30};
		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				drain();
				v = (ph == 4) ? CNT_W'($urandom_range(2, 61)) : CNT_W'(intervals[ph]);
				cfg_wr_en <= 1'b1;
				cfg_wr_data <= v;
				@(posedge clk);
				cfg_wr_en <= 1'b0;
				repeat_interval = v;
			end
			steady_phase = (ph == 2);
			foreach (hot[h]) begin
				hot[h] = $urandom_range(0, SENSORS - 1);
			end
			for (int n = 0; n < 250; n++) begin
				if ($urandom_range(0, 99) < 70) begin
					e = hot[$urandom_range(0, 2)];
				end else begin
					e = $urandom_range(0, SENSORS - 1);
				end
				w.cls = CLASS_W'(e / SENSORS_PER_CLASS_DEF);
				w.idx = INDEX_W'(e % SENSORS_PER_CLASS_DEF);
				w.mask = ($urandom_range(0, 99) < 60) ? 4'hF : MASK_W'($urandom);
				if ($urandom_range(0, 99) < 20) begin
					w.rd = TEMP_W'($urandom);
					w.warn = TEMP_W'($urandom);
					w.high = TEMP_W'($urandom);
					w.crit = TEMP_W'($urandom);
				end else begin
					wn = $urandom_range(2, 3000);
					hi = wn + $urandom_range(1, 3000);
					cr = hi + $urandom_range(1, 3000);
					if ($urandom_range(0, 1) == 0) begin
						last_band[e] = $urandom_range(0, 3);
					end
					band = last_band[e];
					if ($urandom_range(0, 9) == 0) begin
						rd = -int'($urandom_range(0, 32768));
					end else if (band == 0) begin
						rd = $urandom_range(1, wn - 1);
					end else if (band == 1) begin
						rd = $urandom_range(wn, hi - 1);
					end else if (band == 2) begin
						rd = $urandom_range(hi, cr - 1);
					end else begin
						rd = $urandom_range(cr, 32767);
					end
					w.rd = TEMP_W'(rd);
					w.warn = TEMP_W'(wn);
					w.high = TEMP_W'(hi);
					w.crit = TEMP_W'(cr);
				end
				offer(w, 1'b0, '0);
			end
		end

		steady_phase = 1'b0;
		drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
